>>> src/multi_servo_slew_limiter_macros.svh
// assertion macros used by the servo slew limiter top module
`ifndef MULTI_SERVO_SLEW_LIMITER_MACROS_SVH
`define MULTI_SERVO_SLEW_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
`define MSL_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define MSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define MSL_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define MSL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> src/msl_pkg.sv
package msl_pkg;

    localparam int CHANNELS_DEF  = 6;
    localparam int FRAC_BITS_DEF = 16;

    localparam int TICK_W      = 10;
    localparam int TICK_RESET  = 20;
    localparam int IDX_W       = 4;
    localparam int ANGLE_OUT_W = 24;
    localparam int VALUE_W     = 25;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_SET_TARGET = 2'd1,
        ACT_SET_SPEED  = 2'd2,
        ACT_SET_LIMITS = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CLAMPED = 2'd1,
        STATUS_BAD_CH  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_ANGLE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [IDX_W-1:0]        idx;
        logic [ANGLE_OUT_W-1:0]  angle;
        status_t                 status;
    } result_t;

    // power-up table in whole degrees, channels past the table reuse its last row
    localparam int RST_TABLE_LEN = 6;
    localparam logic [7:0] RST_ANGLE_DEG [RST_TABLE_LEN] = '{8'd80, 8'd0, 8'd90, 8'd5,
                                                             8'd121, 8'd10};
    localparam logic [7:0] RST_MIN_DEG [RST_TABLE_LEN]   = '{8'd0, 8'd0, 8'd80, 8'd5,
                                                             8'd30, 8'd10};
    localparam logic [7:0] RST_MAX_DEG [RST_TABLE_LEN]   = '{8'd180, 8'd180, 8'd140, 8'd60,
                                                             8'd121, 8'd70};
    // reset speed is 45 half degrees per second
    localparam int RST_SPEED_HALF_DEG = 45;

endpackage

>>> src/multi_servo_slew_limiter.sv
// write transaction: read, load and apply the entry, then flush; bad channel: flush only
// tick: read, load, step and apply each channel off target, read and load one on target
// one transaction in work at a time; each stepped channel goes through the state ram
// read and the three-stage step multiplier
// aresetn is synchronous: all channels return to their power-up angles, speeds and
// limits at once through per-channel valid bits, tick period returns to 20 ms
`include "multi_servo_slew_limiter_macros.svh"
module multi_servo_slew_limiter import msl_pkg::*; #(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [TICK_W-1:0]             cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [IDX_W-1:0]              s_channel,
    input  logic signed [VALUE_W-1:0]     s_value_a,
    input  logic signed [VALUE_W-1:0]     s_value_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [IDX_W-1:0]              m_servo_index,
    output logic [ANGLE_OUT_W-1:0]        m_angle_out,
    output logic [1:0]                    m_status,
    output logic                          m_last
);

    localparam int AW    = FRAC_BITS + 8;
    localparam int SW    = (FRAC_BITS + 5 > 24) ? FRAC_BITS + 5 : 24;
    localparam int STW   = SW + 1;
    localparam int CW    = ((AW > VALUE_W) ? AW : VALUE_W) + 1;
    localparam int GW    = (AW > STW) ? AW : STW;
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MIN_SPEED_INT = ((2 ** FRAC_BITS) + 5) / 10;

    localparam logic [AW-1:0]        DEG_180     = AW'(180 << FRAC_BITS);
    localparam logic signed [CW-1:0] DEG_180_S   = CW'(180 << FRAC_BITS);
    localparam logic [SW-1:0]        MIN_SPEED   = SW'(MIN_SPEED_INT);
    localparam logic signed [CW-1:0] MIN_SPEED_S = CW'(MIN_SPEED_INT);
    localparam logic [CH_AW-1:0]     LAST_IDX    = CH_AW'(CHANNELS - 1);

    typedef struct packed {
        logic [AW-1:0] cur;
        logic [AW-1:0] tgt;
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        logic [SW-1:0] spd;
    } chan_t;

    localparam int MEM_W = $bits(chan_t);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_STEP  = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    function automatic chan_t reset_entry(input logic [CH_AW-1:0] idx);
        int    r;
        chan_t e;
        r     = (int'(idx) < RST_TABLE_LEN) ? int'(idx) : RST_TABLE_LEN - 1;
        e.cur = AW'(RST_ANGLE_DEG[r]) << FRAC_BITS;
        e.tgt = AW'(RST_ANGLE_DEG[r]) << FRAC_BITS;
        e.lo  = AW'(RST_MIN_DEG[r]) << FRAC_BITS;
        e.hi  = AW'(RST_MAX_DEG[r]) << FRAC_BITS;
        e.spd = SW'(RST_SPEED_HALF_DEG) << (FRAC_BITS - 1);
        return e;
    endfunction

    function automatic logic [AW-1:0] clamp180(input logic signed [VALUE_W-1:0] v);
        logic signed [CW-1:0] w;
        logic [AW-1:0]        res;
        w = CW'(v);
        if (w < 0) begin
            res = '0;
        end else if (w > DEG_180_S) begin
            res = DEG_180;
        end else begin
            res = w[AW-1:0];
        end
        return res;
    endfunction

    state_t                      state_reg, state_next;
    logic [TICK_W-1:0]           tick_reg;
    action_t                     act_reg;
    logic [IDX_W-1:0]            ch_reg;
    logic signed [VALUE_W-1:0]   a_reg, b_reg;
    logic [CH_AW-1:0]            idx_reg;
    logic [CHANNELS-1:0]         valid_reg;
    logic                        rd_valid_reg;
    chan_t                       entry_reg;
    logic [AW-1:0]               lim_lo_reg, lim_hi_reg, gap_reg;
    logic                        up_reg;
    result_t                     pend_reg, out_reg;
    logic                        pend_valid_reg, m_valid_reg, m_last_reg;

    logic [MEM_W-1:0]            ram_q;
    chan_t                       merged, entry_new;
    result_t                     res_new, bad_res;
    logic [AW-1:0]               lo_c, hi_c, moved, tgt_clamped;
    status_t                     clamp_status;
    logic signed [CW-1:0]        cv, clo, chi;
    logic [GW-1:0]               gap_ext, step_ext;
    logic [STW-1:0]              step_q;
    logic                        step_start, step_done;
    logic                        accept, is_bad, out_free, apply_go, out_load, ram_we;
    logic                        skip_ch, idx_adv;

    msl_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (entry_new),
        .raddr (idx_reg),
        .rdata (ram_q)
    );

    msl_step #(
        .SPEED_W (SW)
    ) u_step (
        .clk   (aclk),
        .rstn  (aresetn),
        .start (step_start),
        .speed (merged.spd),
        .tick  (tick_reg),
        .done  (step_done),
        .step  (step_q)
    );

    assign accept   = s_valid && s_ready;
    assign is_bad   = (action_t'(s_action) != ACT_TICK) &&
                      ({1'b0, s_channel} >= (IDX_W+1)'(CHANNELS));
    assign out_free = !m_valid_reg || m_ready;
    assign apply_go = !pend_valid_reg || out_free;

    // never-written entries read as their power-up values
    assign merged = rd_valid_reg ? chan_t'(ram_q) : reset_entry(idx_reg);

    assign lo_c = clamp180(a_reg);
    assign hi_c = clamp180(b_reg);

    assign skip_ch = (act_reg == ACT_TICK) && (merged.cur == merged.tgt);

    // tick move: snap when within one step, otherwise step toward target
    assign gap_ext  = GW'(gap_reg);
    assign step_ext = GW'(step_q);
    always_comb begin
        if (gap_ext <= step_ext) begin
            moved = entry_reg.tgt;
        end else if (up_reg) begin
            moved = AW'(GW'(entry_reg.cur) + step_ext);
        end else begin
            moved = AW'(GW'(entry_reg.cur) - step_ext);
        end
    end

    // target clamp, shared by set target and set limits
    always_comb begin
        if (act_reg == ACT_SET_TARGET) begin
            cv  = CW'(a_reg);
            clo = {{(CW-AW){1'b0}}, entry_reg.lo};
            chi = {{(CW-AW){1'b0}}, entry_reg.hi};
        end else begin
            cv  = {{(CW-AW){1'b0}}, entry_reg.tgt};
            clo = {{(CW-AW){1'b0}}, lim_lo_reg};
            chi = {{(CW-AW){1'b0}}, lim_hi_reg};
        end
        if (cv < clo) begin
            tgt_clamped  = clo[AW-1:0];
            clamp_status = STATUS_CLAMPED;
        end else if (cv > chi) begin
            tgt_clamped  = chi[AW-1:0];
            clamp_status = STATUS_CLAMPED;
        end else begin
            tgt_clamped  = cv[AW-1:0];
            clamp_status = STATUS_OK;
        end
    end

    always_comb begin
        entry_new      = entry_reg;
        res_new.kind   = KIND_STATUS;
        res_new.idx    = ch_reg;
        res_new.angle  = '0;
        res_new.status = STATUS_OK;
        unique case (act_reg)
            ACT_TICK: begin
                entry_new.cur = moved;
                res_new.kind  = KIND_ANGLE;
                res_new.idx   = IDX_W'(idx_reg);
                res_new.angle = ANGLE_OUT_W'(moved);
            end
            ACT_SET_TARGET: begin
                entry_new.tgt  = tgt_clamped;
                res_new.status = clamp_status;
            end
            ACT_SET_SPEED: begin
                entry_new.spd = (CW'(a_reg) < MIN_SPEED_S) ? MIN_SPEED : SW'(a_reg);
            end
            ACT_SET_LIMITS: begin
                entry_new.lo   = lim_lo_reg;
                entry_new.hi   = lim_hi_reg;
                entry_new.tgt  = tgt_clamped;
                res_new.status = clamp_status;
            end
        endcase
    end

    always_comb begin
        bad_res.kind   = KIND_STATUS;
        bad_res.idx    = s_channel;
        bad_res.angle  = '0;
        bad_res.status = STATUS_BAD_CH;
    end

    always_comb begin
        state_next = state_reg;
        step_start = 1'b0;
        idx_adv    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = is_bad ? ST_FLUSH : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (skip_ch) begin
                    idx_adv    = (idx_reg != LAST_IDX);
                    state_next = (idx_reg == LAST_IDX) ? ST_FLUSH : ST_READ;
                end else if (act_reg == ACT_TICK) begin
                    step_start = 1'b1;
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_STEP: begin
                if (step_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_go) begin
                    if (act_reg != ACT_TICK || idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_adv    = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_we   = (state_reg == ST_APPLY) && apply_go;
    // a held result goes out once the next one is found or the walk ends
    assign out_load = pend_valid_reg && out_free &&
                      ((state_reg == ST_APPLY) || (state_reg == ST_FLUSH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= TICK_W'(TICK_RESET);
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                tick_reg <= cfg_wr_data;
            end
            if (ram_we) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (accept && is_bad) begin
                pend_valid_reg <= 1'b1;
            end else if (ram_we) begin
                pend_valid_reg <= 1'b1;
            end else if (state_reg == ST_FLUSH && out_free) begin
                pend_valid_reg <= 1'b0;
            end
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[idx_reg];
        if (accept) begin
            act_reg <= action_t'(s_action);
            ch_reg  <= s_channel;
            a_reg   <= s_value_a;
            b_reg   <= s_value_b;
            idx_reg <= (action_t'(s_action) == ACT_TICK) ? '0 : s_channel[CH_AW-1:0];
            if (is_bad) begin
                pend_reg <= bad_res;
            end
        end else if (idx_adv) begin
            idx_reg <= CH_AW'(idx_reg + 1'b1);
        end
        if (state_reg == ST_READ) begin
            lim_lo_reg <= (lo_c > hi_c) ? hi_c : lo_c;
            lim_hi_reg <= (lo_c > hi_c) ? lo_c : hi_c;
        end
        if (state_reg == ST_LOAD) begin
            entry_reg <= merged;
            up_reg    <= merged.tgt > merged.cur;
            gap_reg   <= (merged.tgt > merged.cur) ? merged.tgt - merged.cur
                                                   : merged.cur - merged.tgt;
        end
        if (ram_we) begin
            pend_reg <= res_new;
        end
        if (out_load) begin
            out_reg    <= pend_reg;
            m_last_reg <= (state_reg == ST_FLUSH);
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_servo_index = out_reg.idx;
    assign m_angle_out   = out_reg.angle;
    assign m_status      = out_reg.status;
    assign m_last        = m_last_reg;

    `MSL_ASSERT_IMPLY(a_angle_status_ok, aclk, aresetn, m_valid && m_kind == KIND_ANGLE, m_status == STATUS_OK)
    `MSL_ASSERT_IMPLY(a_reply_is_last, aclk, aresetn, m_valid && m_kind == KIND_STATUS, m_last)
    `MSL_ASSERT_IMPLY(a_idle_nothing_held, aclk, aresetn, s_ready, !pend_valid_reg)
    `MSL_ASSERT_IMPLY(a_step_when_waiting, aclk, aresetn, step_done, state_reg == ST_STEP)
    `MSL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

>>> src/msl_ram.sv
module msl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/msl_step.sv
module msl_step import msl_pkg::*; #(
    parameter int SPEED_W = 24
) (
    input  logic               clk,
    input  logic               rstn,
    input  logic               start,
    input  logic [SPEED_W-1:0] speed,
    input  logic [TICK_W-1:0]  tick,
    output logic               done,
    output logic [SPEED_W:0]   step
);

    // floor(speed * tick / 1000) = floor(floor(speed * tick / 8) / 125)
    localparam int PW      = SPEED_W + TICK_W;
    localparam int YW      = PW - 3;
    localparam int QW      = YW - 6;
    localparam int ODD_DIV = 125;
    localparam longint unsigned RECIP_L = (longint'(1) << YW) / ODD_DIV;
    localparam logic [QW-1:0] RECIP = QW'(RECIP_L);

    logic [PW-1:0]    prod_reg;
    logic [QW-1:0]    q0_reg;
    logic [7:0]       ylo_reg;
    logic [QW-1:0]    step_reg;
    logic             v1_reg, v2_reg, v3_reg;

    logic [YW-1:0]    y;
    logic [YW+QW-1:0] mul;
    logic [15:0]      back;
    logic [7:0]       rem;

    assign y    = prod_reg[PW-1:3];
    assign mul  = (YW+QW)'(y) * (YW+QW)'(RECIP);
    // quotient estimate is low by at most one, so the remainder stays below 250
    assign back = 16'(q0_reg[7:0]) * 16'd125;
    assign rem  = ylo_reg - back[7:0];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            prod_reg <= PW'(speed) * PW'(tick);
        end
        if (v1_reg) begin
            q0_reg  <= mul[YW+QW-1:YW];
            ylo_reg <= y[7:0];
        end
        if (v2_reg) begin
            step_reg <= q0_reg + QW'(rem >= 8'd125);
        end
    end

    assign done = v3_reg;
    assign step = step_reg;

endmodule
